>>> hdl/fwt_pkg.sv
package fwt_pkg;

    localparam int INDEX_W = 11;
    localparam int POS_W = INDEX_W + 1;
    localparam int DATA_W = 32;
    localparam int SIZE_W = 11;
    localparam int TDATA_W = 48;
    localparam int MAX_POSITIONS_DEF = 1024;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

endpackage

>>> hdl/fwt_ram.sv
module fwt_ram #(
    parameter int DEPTH = fwt_pkg::MAX_POSITIONS_DEF,
    parameter int AW = $clog2(DEPTH),
    parameter int DW = fwt_pkg::DATA_W
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/fwt_ctrl.sv
module fwt_ctrl #(
    parameter int MAX_POSITIONS = fwt_pkg::MAX_POSITIONS_DEF,
    parameter int AW = $clog2(MAX_POSITIONS)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [fwt_pkg::SIZE_W-1:0]       active_size,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_cmd,
    input  logic [fwt_pkg::INDEX_W-1:0]      in_index,
    input  logic [fwt_pkg::DATA_W-1:0]       in_delta,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [fwt_pkg::DATA_W-1:0]       out_sum,
    output logic                             mem_we,
    output logic [AW-1:0]                    mem_waddr,
    output logic [fwt_pkg::DATA_W-1:0]       mem_wdata,
    output logic                             mem_re,
    output logic [AW-1:0]                    mem_raddr,
    input  logic [fwt_pkg::DATA_W-1:0]       mem_rdata
);

    localparam int PW = fwt_pkg::POS_W;
    localparam int XW = (AW > PW) ? AW : PW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POSITIONS - 1);

    fwt_pkg::state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic rd_pend_reg, rd_pend_next;
    logic out_valid_reg, out_valid_next;
    logic cmd_reg, cmd_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [fwt_pkg::SIZE_W-1:0] lim_reg, lim_next;
    logic [fwt_pkg::DATA_W-1:0] delta_reg, delta_next;
    logic [fwt_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic [fwt_pkg::DATA_W-1:0] sum_reg, sum_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;

    logic [PW-1:0] low_bit;
    logic [PW-1:0] step;
    logic step_ok;
    logic [PW-1:0] pos_m1;
    logic [XW-1:0] pos_x;
    logic [AW-1:0] pos_addr;
    logic [fwt_pkg::DATA_W-1:0] acc_sum;
    logic [fwt_pkg::INDEX_W-1:0] q_index;
    logic out_free;

    assign low_bit = pos_reg & (~pos_reg + PW'(1));
    assign step = (cmd_reg == fwt_pkg::CMD_ADD) ? pos_reg + low_bit : pos_reg - low_bit;
    assign step_ok = (step != '0) && (step <= {1'b0, lim_reg});
    assign pos_m1 = pos_reg - PW'(1);
    assign pos_x = XW'(pos_m1);
    assign pos_addr = pos_x[AW-1:0];
    assign acc_sum = acc_reg + (rd_pend_reg ? mem_rdata : '0);
    assign q_index = (in_index > active_size) ? active_size : in_index;
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready = (state_reg == fwt_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_sum = sum_reg;
    assign mem_raddr = pos_addr;

    always_comb
    begin
        state_next = state_reg;
        clr_cnt_next = clr_cnt_reg;
        rd_pend_next = rd_pend_reg;
        out_valid_next = out_valid_reg;
        cmd_next = cmd_reg;
        pos_next = pos_reg;
        lim_next = lim_reg;
        delta_next = delta_reg;
        acc_next = acc_reg;
        sum_next = sum_reg;
        rd_addr_next = rd_addr_reg;
        mem_we = 1'b0;
        mem_waddr = rd_addr_reg;
        mem_wdata = mem_rdata + delta_reg;
        mem_re = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            fwt_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = fwt_pkg::ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            fwt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = in_cmd;
                    delta_next = in_delta;
                    lim_next = active_size;
                    acc_next = '0;
                    rd_pend_next = 1'b0;
                    if (in_cmd == fwt_pkg::CMD_ADD)
                    begin
                        pos_next = {1'b0, in_index};
                        if (in_index != '0 && in_index <= active_size)
                        begin
                            state_next = fwt_pkg::ST_WALK;
                        end
                    end
                    else
                    begin
                        pos_next = {1'b0, q_index};
                        state_next = (q_index != '0) ? fwt_pkg::ST_WALK : fwt_pkg::ST_DRAIN;
                    end
                end
            end
            fwt_pkg::ST_WALK:
            begin
                mem_re = 1'b1;
                rd_pend_next = 1'b1;
                rd_addr_next = pos_addr;
                pos_next = step;
                if (rd_pend_reg)
                begin
                    if (cmd_reg == fwt_pkg::CMD_ADD)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_sum;
                    end
                end
                if (!step_ok)
                begin
                    state_next = fwt_pkg::ST_DRAIN;
                end
            end
            fwt_pkg::ST_DRAIN:
            begin
                rd_pend_next = 1'b0;
                acc_next = acc_sum;
                if (cmd_reg == fwt_pkg::CMD_ADD)
                begin
                    mem_we = rd_pend_reg;
                    state_next = fwt_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    sum_next = acc_sum;
                    state_next = fwt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fwt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fwt_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            rd_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cmd_reg <= fwt_pkg::CMD_ADD;
        end
        else
        begin
            state_reg <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            rd_pend_reg <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            cmd_reg <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        lim_reg <= lim_next;
        delta_reg <= delta_next;
        acc_reg <= acc_next;
        sum_reg <= sum_next;
        rd_addr_reg <= rd_addr_next;
    end

endmodule

>>> hdl/fenwick_tree_prefix_sum.sv
// channel   | direction | signals                              | contents
// ----------+-----------+--------------------------------------+-------------------------------
// s_axis    | in        | s_tvalid s_tready s_tuser s_tdata    | command: add or prefix query
// m_axis    | out       | m_tvalid m_tready m_tdata            | prefix sum, queries only
// cfg       | in        | cfg_we cfg_wdata                     | size_in_use
//
// an add touching k tree entries reads each and writes it back plus delta; a query sums the k
// entries it reads; the walk makes one read per cycle of the tree memory and k is at most
// log2(MAX_POSITIONS)+1; after reset a clearing pass writes zero to all MAX_POSITIONS entries,
// one per cycle, and s_tready stays low until the pass is done; a query ends once output is free
// a finished sum waits in the output register; the next command is taken meanwhile
module fenwick_tree_prefix_sum #(
    parameter int MAX_POSITIONS = fwt_pkg::MAX_POSITIONS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic                               s_tuser,    // cmd
    input  logic [fwt_pkg::TDATA_W-1:0]        s_tdata,    // index[10:0], delta[42:11]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fwt_pkg::DATA_W-1:0]         m_tdata,    // prefix_sum[31:0]
    input  logic                               cfg_we,
    input  logic [fwt_pkg::SIZE_W-1:0]         cfg_wdata
);

    localparam int AW = $clog2(MAX_POSITIONS);

    logic [fwt_pkg::SIZE_W-1:0] size_reg;
    logic [fwt_pkg::SIZE_W-1:0] active_size;
    logic mem_we;
    logic [AW-1:0] mem_waddr;
    logic [fwt_pkg::DATA_W-1:0] mem_wdata;
    logic mem_re;
    logic [AW-1:0] mem_raddr;
    logic [fwt_pkg::DATA_W-1:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= fwt_pkg::SIZE_RESET;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
        end
    end

    assign active_size = (32'(size_reg) > 32'(MAX_POSITIONS))
                       ? fwt_pkg::SIZE_W'(MAX_POSITIONS) : size_reg;

    fwt_ctrl #(
        .MAX_POSITIONS(MAX_POSITIONS),
        .AW(AW)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .active_size(active_size),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .in_cmd(s_tuser),
        .in_index(s_tdata[fwt_pkg::INDEX_W-1:0]),
        .in_delta(s_tdata[fwt_pkg::INDEX_W+fwt_pkg::DATA_W-1:fwt_pkg::INDEX_W]),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_sum(m_tdata),
        .mem_we(mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_re(mem_re),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata)
    );

    fwt_ram #(
        .DEPTH(MAX_POSITIONS),
        .AW(AW),
        .DW(fwt_pkg::DATA_W)
    ) u_ram (
        .clk(clk),
        .we(mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re(mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

endmodule

>>> tb/sv/fenwick_tree_prefix_sum_tb.sv
module fenwick_tree_prefix_sum_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PAD_W = fwt_pkg::TDATA_W - fwt_pkg::DATA_W - fwt_pkg::INDEX_W;
    localparam int NUM_ROWS = 25;
    localparam int NUM_PHASES = 8;

    localparam bit KEEP = 1'b0;
    localparam bit RESIZE = 1'b1;
    localparam bit PREDICT = 1'b0;
    localparam bit KNOWN = 1'b1;

    typedef struct packed {
        bit                          set_size;
        logic [fwt_pkg::SIZE_W-1:0]  size;
        logic                        cmd;
        logic [fwt_pkg::INDEX_W-1:0] idx;
        logic [fwt_pkg::DATA_W-1:0]  delta;
        bit                          known;
        logic [fwt_pkg::DATA_W-1:0]  sum;
    } cmd_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic                         s_tuser;
    logic [fwt_pkg::TDATA_W-1:0]  s_tdata;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [fwt_pkg::DATA_W-1:0]   m_tdata;
    logic                         cfg_we;
    logic [fwt_pkg::SIZE_W-1:0]   cfg_wdata;

    logic [fwt_pkg::DATA_W-1:0]   shadow_tree [1:fwt_pkg::MAX_POSITIONS_DEF];
    logic [fwt_pkg::SIZE_W-1:0]   size_reg;
    logic [fwt_pkg::DATA_W-1:0]   pending_sums [$];
    logic [fwt_pkg::DATA_W-1:0]   want_sum;
    int                           mismatches = 0;
    int                           cycle_count = 0;
    int                           send_idle_pct = 0;
    int                           recv_idle_pct = 0;
    int                           hold_seq = 0;
    int                           hold_seen = 0;
    int                           hold_left = 0;
    int                           phase;
    int                           item;
    int                           item_count;
    logic [fwt_pkg::SIZE_W-1:0]   phase_size;

    cmd_row_t directed_rows [0:NUM_ROWS-1] = '{
        '{KEEP,   11'd0,    fwt_pkg::CMD_QUERY, 11'd0,    32'h0000_0000, KNOWN,   32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_QUERY, 11'd1024, 32'h0000_0000, KNOWN,   32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_QUERY, 11'd2047, 32'hFFFF_FFFF, KNOWN,   32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_ADD,   11'd0,    32'h7FFF_FFFF, PREDICT, 32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_ADD,   11'd1025, 32'h0000_0005, PREDICT, 32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_ADD,   11'd2047, 32'hFFFF_FFFF, PREDICT, 32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_QUERY, 11'd2047, 32'h0000_0000, KNOWN,   32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_ADD,   11'd1,    32'h7FFF_FFFF, PREDICT, 32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_ADD,   11'd1024, 32'h8000_0000, PREDICT, 32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_ADD,   11'd1,    32'h0000_0001, PREDICT, 32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_ADD,   11'd512,  32'hFFFF_FFFF, PREDICT, 32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_ADD,   11'd1023, 32'hAAAA_AAAA, PREDICT, 32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_ADD,   11'd682,  32'h5555_5555, PREDICT, 32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_QUERY, 11'd1,    32'h0000_0000, PREDICT, 32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_QUERY, 11'd683,  32'h0000_0000, PREDICT, 32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_QUERY, 11'd1023, 32'h0000_0000, PREDICT, 32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_QUERY, 11'd1024, 32'h0000_0000, PREDICT, 32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_QUERY, 11'd1500, 32'h0000_0000, PREDICT, 32'h0},
        '{RESIZE, 11'd0,    fwt_pkg::CMD_ADD,   11'd3,    32'h1234_5678, PREDICT, 32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_QUERY, 11'd3,    32'h0000_0000, KNOWN,   32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_QUERY, 11'd2047, 32'h0000_0000, KNOWN,   32'h0},
        '{RESIZE, 11'd2047, fwt_pkg::CMD_ADD,   11'd1024, 32'h0000_0010, PREDICT, 32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_QUERY, 11'd2047, 32'h0000_0000, PREDICT, 32'h0},
        '{RESIZE, 11'd1,    fwt_pkg::CMD_ADD,   11'd1,    32'h0000_0003, PREDICT, 32'h0},
        '{KEEP,   11'd0,    fwt_pkg::CMD_QUERY, 11'd1024, 32'h0000_0000, PREDICT, 32'h0}
    };

    logic [fwt_pkg::SIZE_W-1:0] phase_sizes [0:NUM_PHASES-1] = '{
        11'd2, 11'd7, 11'd1025, 11'd0, 11'd16, 11'd0, 11'd1, 11'd1024
    };

    fenwick_tree_prefix_sum dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic int unsigned live_size();
        return (size_reg > fwt_pkg::MAX_POSITIONS_DEF) ? fwt_pkg::MAX_POSITIONS_DEF
                                                       : int'(size_reg);
    endfunction

    task automatic apply_add(input int unsigned pos,
                             input logic [fwt_pkg::DATA_W-1:0] amount);
        int unsigned lim;
        int unsigned i;
        begin
            lim = live_size();
            i = pos;
            if (i != 0 && i <= lim)
            begin
                while (i != 0 && i <= lim)
                begin
                    shadow_tree[i] = shadow_tree[i] + amount;
                    i = i + (i & (~i + 1));
                end
            end
        end
    endtask

    function automatic logic [fwt_pkg::DATA_W-1:0] prefix_total(input int unsigned pos);
        int unsigned i;
        logic [fwt_pkg::DATA_W-1:0] acc;
        begin
            i = (pos > live_size()) ? live_size() : pos;
            acc = '0;
            while (i != 0)
            begin
                acc = acc + shadow_tree[i];
                i = i - (i & (~i + 1));
            end
            return acc;
        end
    endfunction

    task automatic send_cmd(input logic cmd, input logic [fwt_pkg::INDEX_W-1:0] idx,
                            input logic [fwt_pkg::DATA_W-1:0] delta, input bit known,
                            input logic [fwt_pkg::DATA_W-1:0] known_sum);
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
            @(negedge clk);
            s_tvalid <= 1'b1;
            s_tuser <= cmd;
            s_tdata <= {{PAD_W{1'b0}}, delta, idx};
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            if (cmd == fwt_pkg::CMD_ADD)
                apply_add(32'(idx), delta);
            else
                pending_sums.push_back(known ? known_sum : prefix_total(32'(idx)));
        end
    endtask

    task automatic send_random();
        int unsigned lim;
        int unsigned pick;
        int unsigned idx;
        logic cmd;
        logic [fwt_pkg::DATA_W-1:0] delta;
        begin
            lim = live_size();
            pick = $urandom_range(0, 99);
            delta = $urandom;
            if (pick < 10)
            begin
                // noise: any command at any index
                cmd = 1'($urandom_range(0, 1));
                idx = $urandom_range(0, 2047);
            end
            else if (pick < 55)
            begin
                cmd = fwt_pkg::CMD_ADD;
                idx = (lim == 0) ? 0 : $urandom_range(1, lim);
                if ($urandom_range(0, 1))
                    delta = $urandom_range(0, 200) - 100;
            end
            else
            begin
                cmd = fwt_pkg::CMD_QUERY;
                idx = $urandom_range(0, lim);
            end
            send_cmd(cmd, idx[fwt_pkg::INDEX_W-1:0], delta, PREDICT, '0);
        end
    endtask

    task automatic change_size(input logic [fwt_pkg::SIZE_W-1:0] value);
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            while (pending_sums.size() != 0)
                @(posedge clk);
            // adds give no transfer, let the last one finish
            repeat (SETTLE_CYCLES) @(posedge clk);
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_wdata <= value;
            @(negedge clk);
            cfg_we <= 1'b0;
            size_reg = value;
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_sums.size() == 0)
            begin
                $display("%0t: prefix sum transfer with none expected, actual %h",
                         $time, m_tdata);
                mismatches = mismatches + 1;
            end
            else
            begin
                want_sum = pending_sums.pop_front();
                if (m_tdata !== want_sum)
                begin
                    $display("%0t: prefix sum mismatch, expected %h actual %h",
                             $time, want_sum, m_tdata);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("fenwick_tree_prefix_sum verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        size_reg = fwt_pkg::SIZE_RESET;
        for (int k = 1; k <= fwt_pkg::MAX_POSITIONS_DEF; k++)
            shadow_tree[k] = '0;
        send_idle_pct = 30;
        recv_idle_pct = 60;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].set_size)
                change_size(directed_rows[r].size);
            send_cmd(directed_rows[r].cmd, directed_rows[r].idx, directed_rows[r].delta,
                     directed_rows[r].known, directed_rows[r].sum);
        end

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase < 3)
            begin
                send_idle_pct = 30;
                recv_idle_pct = 60;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 60;
                recv_idle_pct = 30;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            phase_size = (phase == 5) ? fwt_pkg::SIZE_W'($urandom_range(3, 1023))
                                      : phase_sizes[phase];
            change_size(phase_size);
            // long output stall so the block backs up into its input
            if (phase == 1)
                hold_seq = hold_seq + 1;
            item_count = (phase_size == 0) ? 16 : 55;
            for (item = 0; item < item_count; item++)
                send_random();
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("fenwick_tree_prefix_sum verification clean");
        else
            $display("fenwick_tree_prefix_sum verification failed");
        $finish;
    end

endmodule

>>> files.f
hdl/fwt_pkg.sv
hdl/fwt_ram.sv
hdl/fwt_ctrl.sv
hdl/fenwick_tree_prefix_sum.sv
tb/sv/fenwick_tree_prefix_sum_tb.sv
